// ===== sv/tspn_pkg.sv =====
// Shared types, constants and bit functions of the 16-bit SPN cipher unit.
package tspn_pkg;

   // Table geometry
   localparam int TBL_WIDTH = 8;
   localparam int TBL_DEPTH = 256;

   // Item commands
   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_ENC  = 2'd1;
   localparam logic [1:0] CMD_DEC  = 2'd2;

   // CSR indexes
   localparam logic CSR_KEY  = 1'b0;
   localparam logic CSR_PERM = 1'b1;

   // CSR reset values
   localparam logic [15:0] KEY_RESET  = 16'h0000;
   localparam logic [23:0] PERM_RESET = 24'hFAC688;

   // Key schedule round constants
   localparam logic [7:0] KS_RCON1 = 8'h80;
   localparam logic [7:0] KS_RCON2 = 8'h30;

   // Cipher rounds
   localparam int NUM_ROUNDS = 3;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  table_index;
      logic [7:0]  table_value;
      logic [15:0] block_in;
   } req_type;

   typedef struct packed {
      logic [15:0] block_out;
      logic        status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_step;
      logic load_we;
      logic start;
      logic ks_a;
      logic ks_b;
      logic ks_c;
      logic rd_cap;
      logic rsp_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic perm_ok;
      logic rnd_last;
      logic out_free;
   } dp_sts_type;

   function automatic logic [7:0] nib_swap(input logic [7:0] b);
      nib_swap = {b[3:0], b[7:4]};
   endfunction

   // True when the eight 3-bit fields name every position once
   function automatic logic perm_is_ok(input logic [23:0] p);
      logic [7:0] seen;
      seen = '0;
      for (int i = 0; i < 8; i++) begin
         seen = seen | (8'b1 << p[3*i +: 3]);
      end
      perm_is_ok = (seen == 8'hFF);
   endfunction

   // Output position i (bit 7-i) takes source position f_i (bit 7-f_i)
   function automatic logic [7:0] perm_fwd(input logic [7:0] x, input logic [23:0] p);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = x[3'd7 - p[3*i +: 3]];
      end
      perm_fwd = r;
   endfunction

   function automatic logic [7:0] perm_inv(input logic [7:0] y, input logic [23:0] p);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[3'd7 - p[3*i +: 3]] = r[3'd7 - p[3*i +: 3]] | y[7-i];
      end
      perm_inv = r;
   endfunction

endpackage

// ===== sv/tspn_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module tspn_ram
   #(
      parameter int WIDTH = 8,
      parameter int DEPTH = 256
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
      input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
      output logic [WIDTH-1:0]         rd_data_a,
      output logic [WIDTH-1:0]         rd_data_b
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== sv/tspn_datapath.sv =====
// Datapath: CSRs, table memories, key schedule, round registers, result register.
module tspn_datapath
   import tspn_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      input  dp_cmd_type cmd,
      output dp_sts_type sts,
      input  req_type    req_data,
      output logic       rsp_valid,
      input  logic       rsp_ready,
      output rsp_type    rsp_data,
      input  logic       csr_we,
      input  logic       csr_index,
      input  logic [23:0] csr_wdata
   );

   localparam int AW = $clog2(TBL_DEPTH);

   logic [15:0]    key_ff, key_in;
   logic [23:0]    perm_ff, perm_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           dec_ff, dec_in;
   logic           err_ff, err_in;
   logic [7:0]     w2_ff, w2_in, w3_ff, w3_in, w4_ff, w4_in, w5_ff, w5_in;
   logic [7:0]     hi_ff, hi_in, lo_ff, lo_in;
   logic [1:0]     rnd_ff, rnd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           tbl_we;
   logic [AW-1:0]  sbox_waddr, inv_waddr;
   logic [7:0]     sbox_wdata, inv_wdata;
   logic [AW-1:0]  rd_addr_a, rd_addr_b;
   logic [7:0]     sbox_a, sbox_b, inv_a, inv_b;
   logic [7:0]     w2_new, w3_new, w4_new;
   logic [15:0]    rkey;
   logic [1:0]     rnd_idx;

   // Table writes: clearing pass after reset, or a load word
   assign tbl_we     = cmd.clr_step | cmd.load_we;
   assign sbox_waddr = cmd.clr_step ? clr_cnt_ff : req_data.table_index;
   assign sbox_wdata = cmd.clr_step ? 8'h00 : req_data.table_value;
   assign inv_waddr  = cmd.clr_step ? clr_cnt_ff : req_data.table_value;
   assign inv_wdata  = cmd.clr_step ? 8'h00 : req_data.table_index;

   tspn_ram #(.WIDTH(TBL_WIDTH), .DEPTH(TBL_DEPTH)) u_sbox_ram (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (sbox_waddr),
      .wr_data   (sbox_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (sbox_a),
      .rd_data_b (sbox_b)
   );

   tspn_ram #(.WIDTH(TBL_WIDTH), .DEPTH(TBL_DEPTH)) u_inv_ram (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (inv_waddr),
      .wr_data   (inv_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (inv_a),
      .rd_data_b (inv_b)
   );

   // Key schedule words
   assign w2_new = key_ff[15:8] ^ KS_RCON1 ^ sbox_a;
   assign w3_new = w2_new ^ key_ff[7:0];
   assign w4_new = w2_ff ^ KS_RCON2 ^ sbox_a;

   // Round subkey: encrypt walks k0..k2, decrypt k2..k0
   always_comb begin
      rnd_idx = dec_ff ? (2'd2 - rnd_ff) : rnd_ff;
      if (rnd_idx == 2'd0) begin
         rkey = key_ff;
      end else if (rnd_idx == 2'd1) begin
         rkey = {w2_ff, w3_ff};
      end else begin
         rkey = {w4_ff, w5_ff};
      end
   end

   // Table read addresses
   always_comb begin
      if (cmd.ks_a) begin
         rd_addr_a = nib_swap(key_ff[7:0]);
         rd_addr_b = nib_swap(key_ff[7:0]);
      end else if (cmd.ks_b) begin
         rd_addr_a = nib_swap(w3_new);
         rd_addr_b = nib_swap(w3_new);
      end else if (dec_ff) begin
         rd_addr_a = perm_inv(hi_ff, perm_ff);
         rd_addr_b = perm_inv(lo_ff, perm_ff);
      end else begin
         rd_addr_a = hi_ff ^ rkey[15:8];
         rd_addr_b = lo_ff ^ rkey[7:0];
      end
   end

   // Next-state logic
   always_comb begin
      key_in       = key_ff;
      perm_in      = perm_ff;
      clr_cnt_in   = clr_cnt_ff;
      dec_in       = dec_ff;
      err_in       = err_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      w4_in        = w4_ff;
      w5_in        = w5_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // CSR writes
      if (csr_we) begin
         case (csr_index)
            CSR_KEY: begin
               key_in = csr_wdata[15:0];
            end
            CSR_PERM: begin
               perm_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      // Take a new block
      if (cmd.start) begin
         dec_in = (req_data.command == CMD_DEC);
         err_in = !perm_is_ok(perm_ff);
         hi_in  = req_data.block_in[15:8];
         lo_in  = req_data.block_in[7:0];
         rnd_in = 2'd0;
      end

      if (cmd.ks_b) begin
         w2_in = w2_new;
         w3_in = w3_new;
      end

      if (cmd.ks_c) begin
         w4_in = w4_new;
         w5_in = w4_new ^ w3_ff;
      end

      // Capture one round of both bytes
      if (cmd.rd_cap) begin
         if (dec_ff) begin
            hi_in = inv_a ^ rkey[15:8];
            lo_in = inv_b ^ rkey[7:0];
         end else begin
            hi_in = perm_fwd(sbox_a, perm_ff);
            lo_in = perm_fwd(sbox_b, perm_ff);
         end
         rnd_in = rnd_ff + 1'b1;
      end

      // Output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.block_out = err_ff ? 16'h0000 : {hi_ff, lo_ff};
         rsp_in.status    = err_ff;
      end
   end

   // Control and CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= KEY_RESET;
         perm_ff      <= PERM_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         perm_ff      <= perm_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
      err_ff <= err_in;
      w2_ff  <= w2_in;
      w3_ff  <= w3_in;
      w4_ff  <= w4_in;
      w5_ff  <= w5_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      rnd_ff <= rnd_in;
      rsp_ff <= rsp_in;
   end

   // Status
   assign sts.clr_last = (clr_cnt_ff == AW'(TBL_DEPTH - 1));
   assign sts.perm_ok  = perm_is_ok(perm_ff);
   assign sts.rnd_last = (rnd_ff == 2'(NUM_ROUNDS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/tspn_ctrl.sv =====
// Controller: sequences table clearing, loads, key schedule and rounds.
module tspn_ctrl
   import tspn_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      input  logic       req_valid,
      output logic       req_ready,
      input  logic [1:0] req_command,
      input  dp_sts_type sts,
      output dp_cmd_type cmd
   );

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_KEY_A  = 8'b0000_0100,
      ST_KEY_B  = 8'b0000_1000,
      ST_KEY_C  = 8'b0001_0000,
      ST_CAP    = 8'b0010_0000,
      ST_ISSUE  = 8'b0100_0000,
      ST_RESULT = 8'b1000_0000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load_we = 1'b1;
               end else if (req_command inside {CMD_ENC, CMD_DEC}) begin
                  cmd.start = 1'b1;
                  state_in  = sts.perm_ok ? ST_KEY_A : ST_RESULT;
               end
            end
         end
         ST_KEY_A: begin
            cmd.ks_a = 1'b1;
            state_in = ST_KEY_B;
         end
         ST_KEY_B: begin
            cmd.ks_b = 1'b1;
            state_in = ST_KEY_C;
         end
         ST_KEY_C: begin
            // also presents the first round's table reads
            cmd.ks_c = 1'b1;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            cmd.rd_cap = 1'b1;
            state_in   = sts.rnd_last ? ST_RESULT : ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_CAP;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/tiny_spn_block_cipher_16bit_unit.sv =====
// Top level: 16-bit three-round SPN cipher with loadable S-box.
// Encrypt/decrypt: the result is set by two dependent key-schedule reads and three
// read/capture rounds on the tables; no new word is taken until the result is registered.
// Load words are written while idle; a failed permutation check goes straight to the result.
// An untaken result stalls the next one until rsp_ready. Synchronous reset restores CSR
// defaults, then a pass zeroes all 256 entries of both tables with req_ready low.
module tiny_spn_block_cipher_16bit_unit
   import tspn_pkg::*;
   (
      input  logic        clock,
      input  logic        reset,
      input  logic        req_valid,
      output logic        req_ready,
      input  req_type     req_data,
      output logic        rsp_valid,
      input  logic        rsp_ready,
      output rsp_type     rsp_data,
      input  logic        csr_we,
      input  logic        csr_index,
      input  logic [23:0] csr_wdata
   );

   dp_cmd_type cmd;
   dp_sts_type sts;

   tspn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .sts         (sts),
      .cmd         (cmd)
   );

   tspn_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== dv/tiny_spn_block_cipher_16bit_unit_tb.sv =====
// Testbench for the 16-bit SPN cipher unit: scoreboard against a behavioral cipher model.
`timescale 1ns / 1ps

module tiny_spn_block_cipher_16bit_unit_tb;
   import tspn_pkg::*;

   // Command code the block ignores
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   // Bit order reversal: field i names position 7-i
   localparam logic [23:0] PERM_REVERSE = 24'h053977;
   // Idle cycles after the last result before touching a CSR
   localparam int          SETTLE_CYC   = 12;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [23:0] csr_wdata;

   // Words waiting to be sent, and cipher results not yet returned
   req_type     cmd_words_q[$];
   rsp_type     cipher_results_q[$];

   // Cipher model state
   logic [7:0]  sbox_tbl [0:TBL_DEPTH-1];
   logic [7:0]  sbox_inv [0:TBL_DEPTH-1];
   logic [15:0] key_reg;
   logic [23:0] perm_reg;

   // S-box contents as the stimulus will have left them, tracked at queue time
   logic [7:0]  plan_sbox [0:TBL_DEPTH-1];

   int          send_idle_pct;
   int          recv_idle_pct;
   int          fail_count;
   rsp_type     want;

   tiny_spn_block_cipher_16bit_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Cipher model
   // ---------------------------------------------------------------

   // Every position named exactly once
   function automatic logic perm_complete(input logic [23:0] p);
      logic [7:0] hit;
      hit = '0;
      for (int i = 0; i < 8; i++) begin
         hit[p[3*i +: 3]] = 1'b1;
      end
      return hit == 8'hFF;
   endfunction

   // Output position i (bit 7-i) pulls from source position p_i (bit 7-p_i)
   function automatic logic [7:0] bit_shuffle(input logic [7:0] x, input logic [23:0] p);
      logic [7:0] y;
      logic [2:0] src;
      for (int i = 0; i < 8; i++) begin
         src = p[3*i +: 3];
         y[7-i] = x[7-src];
      end
      return y;
   endfunction

   // Only used with a complete permutation, so each source bit is written once
   function automatic logic [7:0] bit_unshuffle(input logic [7:0] y, input logic [23:0] p);
      logic [7:0] x;
      logic [2:0] src;
      x = '0;
      for (int i = 0; i < 8; i++) begin
         src = p[3*i +: 3];
         x[7-src] = y[7-i];
      end
      return x;
   endfunction

   // Update the tables for a load, or queue the block an encrypt/decrypt produces
   task automatic spn_apply(input req_type w);
      rsp_type     res;
      logic [7:0]  w2, w3, w4, hi, lo;
      logic [15:0] rk [0:NUM_ROUNDS-1];
      case (w.command)
         CMD_LOAD: begin
            sbox_tbl[w.table_index] = w.table_value;
            sbox_inv[w.table_value] = w.table_index;
         end
         CMD_ENC, CMD_DEC: begin
            if (!perm_complete(perm_reg)) begin
               res.block_out = 16'h0000;
               res.status    = 1'b1;
            end else begin
               // key schedule: two dependent S-box lookups on nibble-swapped bytes
               w2 = key_reg[15:8] ^ KS_RCON1 ^ sbox_tbl[{key_reg[3:0], key_reg[7:4]}];
               w3 = w2 ^ key_reg[7:0];
               w4 = w2 ^ KS_RCON2 ^ sbox_tbl[{w3[3:0], w3[7:4]}];
               rk[0] = key_reg;
               rk[1] = {w2, w3};
               rk[2] = {w4, w4 ^ w3};
               hi = w.block_in[15:8];
               lo = w.block_in[7:0];
               if (w.command == CMD_ENC) begin
                  for (int r = 0; r < NUM_ROUNDS; r++) begin
                     hi = bit_shuffle(sbox_tbl[hi ^ rk[r][15:8]], perm_reg);
                     lo = bit_shuffle(sbox_tbl[lo ^ rk[r][7:0]], perm_reg);
                  end
               end else begin
                  for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
                     hi = sbox_inv[bit_unshuffle(hi, perm_reg)] ^ rk[r][15:8];
                     lo = sbox_inv[bit_unshuffle(lo, perm_reg)] ^ rk[r][7:0];
                  end
               end
               res.block_out = {hi, lo};
               res.status    = 1'b0;
            end
            cipher_results_q.push_back(res);
         end
         default: ; // unused command: no effect
      endcase
   endtask

   // ---------------------------------------------------------------
   // Request driver: model updated on each accepted word
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            spn_apply(req_data);
         end
         if (!req_valid || req_ready) begin
            if (cmd_words_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= cmd_words_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cipher_results_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual block_out=%h status=%b",
                     $time, rsp_data.block_out, rsp_data.status);
            fail_count++;
         end else begin
            want = cipher_results_q.pop_front();
            if (rsp_data.block_out !== want.block_out) begin
               $display("%0t: block_out mismatch, expected %h actual %h",
                        $time, want.block_out, rsp_data.block_out);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %b actual %b",
                        $time, want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_word(input logic [1:0] cmd, input logic [7:0] idx,
                            input logic [7:0] val, input logic [15:0] blk);
      req_type w;
      w.command     = cmd;
      w.table_index = idx;
      w.table_value = val;
      w.block_in    = blk;
      cmd_words_q.push_back(w);
      if (cmd == CMD_LOAD) begin
         plan_sbox[idx] = val;
      end
   endtask

   // CSR write while the block is idle; model follows immediately
   task automatic write_csr(input logic idx, input logic [23:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_KEY) begin
         key_reg = data[15:0];
      end else begin
         perm_reg = data;
      end
      @(negedge clock);
   endtask

   // Wait until every word is sent and answered, then let trailing work finish
   task automatic settle();
      while (cmd_words_q.size() != 0 || req_valid || cipher_results_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_block();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 16'h0000;
      if (r < 10) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [23:0] random_perm();
      logic [2:0] pos [0:7];
      logic [2:0] t;
      logic [23:0] p;
      int j;
      for (int i = 0; i < 8; i++) begin
         pos[i] = 3'(i);
      end
      for (int i = 7; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = pos[i];
         pos[i] = pos[j];
         pos[j] = t;
      end
      for (int i = 0; i < 8; i++) begin
         p[3*i +: 3] = pos[i];
      end
      return p;
   endfunction

   // Mostly ciphering; some entry swaps that keep the S-box a permutation; some noise
   task automatic push_random(input int n);
      int         r;
      logic [7:0] a, b, va, vb;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 42) begin
            push_word(CMD_ENC, 8'($urandom), 8'($urandom), pick_block());
         end else if (r < 84) begin
            push_word(CMD_DEC, 8'($urandom), 8'($urandom), pick_block());
         end else if (r < 90) begin
            a  = 8'($urandom);
            b  = 8'($urandom);
            va = plan_sbox[a];
            vb = plan_sbox[b];
            push_word(CMD_LOAD, a, vb, 16'($urandom));
            push_word(CMD_LOAD, b, va, 16'($urandom));
         end else if (r < 95) begin
            push_word(CMD_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
         end else begin
            push_word(CMD_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      logic [7:0] order [0:TBL_DEPTH-1];
      logic [7:0] t;
      int         j;

      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = CSR_KEY;
      csr_wdata = '0;
      fail_count    = 0;
      send_idle_pct = 23;
      recv_idle_pct = 65;
      key_reg  = KEY_RESET;
      perm_reg = PERM_RESET;
      for (int i = 0; i < TBL_DEPTH; i++) begin
         sbox_tbl[i]  = '0;
         sbox_inv[i]  = '0;
         plan_sbox[i] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: cipher on zeroed tables, unused command, stale inverse entry
      push_word(CMD_ENC,    8'h00, 8'h00, 16'h0000);
      push_word(CMD_DEC,    8'hFF, 8'hFF, 16'hFFFF);
      push_word(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF);
      push_word(CMD_LOAD,   8'hFF, 8'h00, 16'h0000);
      push_word(CMD_LOAD,   8'h00, 8'hFF, 16'hFFFF);
      push_word(CMD_LOAD,   8'h5A, 8'hA5, 16'h0000);
      push_word(CMD_LOAD,   8'h5A, 8'h3C, 16'h0000);
      push_word(CMD_ENC,    8'h00, 8'h00, 16'hFFFF);
      push_word(CMD_DEC,    8'h00, 8'h00, 16'h0000);
      push_word(CMD_ENC,    8'h00, 8'h00, 16'h1234);
      push_word(CMD_DEC,    8'h00, 8'h00, 16'hA5A5);
      push_word(CMD_UNUSED, 8'h00, 8'h00, 16'h0000);
      settle();

      // Repeated permutation positions: error status
      write_csr(CSR_KEY,  24'hFFFFFF);
      write_csr(CSR_PERM, 24'h000000);
      push_word(CMD_ENC,    8'h00, 8'h00, 16'hFFFF);
      push_word(CMD_DEC,    8'h00, 8'h00, 16'h0000);
      push_word(CMD_UNUSED, 8'h00, 8'h00, 16'h0000);
      push_word(CMD_LOAD,   8'h01, 8'h02, 16'h0000);
      push_word(CMD_ENC,    8'h00, 8'h00, 16'h8001);
      settle();

      // Full random S-box, random key and permutation
      write_csr(CSR_KEY,  24'($urandom));
      write_csr(CSR_PERM, random_perm());
      for (int i = 0; i < TBL_DEPTH; i++) begin
         order[i] = 8'(i);
      end
      for (int i = TBL_DEPTH - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < TBL_DEPTH; i++) begin
         push_word(CMD_LOAD, 8'(i), order[i], 16'($urandom));
      end
      push_random(110);
      settle();

      // Swap the idle roles
      send_idle_pct = 65;
      recv_idle_pct = 23;
      write_csr(CSR_KEY,  24'h000000);
      write_csr(CSR_PERM, PERM_REVERSE);
      push_random(130);
      settle();

      write_csr(CSR_KEY,  24'($urandom));
      write_csr(CSR_PERM, 24'hFFFFFF);
      push_random(20);
      settle();

      // No idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_KEY,  24'h00FFFF);
      write_csr(CSR_PERM, random_perm());
      push_random(130);
      settle();

      write_csr(CSR_KEY,  24'($urandom));
      write_csr(CSR_PERM, PERM_RESET);
      push_random(80);
      settle();

      if (fail_count == 0) begin
         $display("PASS tiny_spn_block_cipher_16bit_unit");
      end else begin
         $display("FAIL tiny_spn_block_cipher_16bit_unit");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAIL tiny_spn_block_cipher_16bit_unit");
      $finish;
   end

endmodule

// ===== tiny_spn_block_cipher_16bit_unit.f =====
sv/tspn_pkg.sv
sv/tspn_ram.sv
sv/tspn_datapath.sv
sv/tspn_ctrl.sv
sv/tiny_spn_block_cipher_16bit_unit.sv
dv/tiny_spn_block_cipher_16bit_unit_tb.sv
